// File: hdl/cdvh_pkg.sv
`timescale 1ns / 1ps
package cdvh_pkg;

  localparam int ZONE_COUNT  = 16;
  localparam int LEVEL_COUNT = 110;
  localparam int COUNT_BITS  = 20;

  localparam int ZONE_W    = 4;
  localparam int DOSE_W    = 16;
  localparam int LEVEL_W   = 7;
  localparam int PCT_W     = 14;
  localparam int TD_W      = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // one bin per zone and per number of levels passed (0 .. LEVEL_COUNT)
  localparam int ROW_STRIDE = LEVEL_COUNT + 1;
  localparam int BIN_DEPTH  = ZONE_COUNT * ROW_STRIDE;
  localparam int BIN_AW     = $clog2(BIN_DEPTH);
  localparam int ARG_W      = ($clog2(LEVEL_COUNT + 1) > LEVEL_W) ?
                              $clog2(LEVEL_COUNT + 1) : LEVEL_W;

  localparam int SRCH_W  = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int SB_W    = (SRCH_W > 1) ? $clog2(SRCH_W) : 1;
  localparam int SCALE_W = DOSE_W + 7;
  localparam int PROD_W  = (TD_W + SRCH_W + 1 > SCALE_W) ? TD_W + SRCH_W + 1 : SCALE_W + 1;

  localparam int SUM_W = COUNT_BITS + ARG_W;
  localparam int DVD_W = COUNT_BITS + PCT_W;
  localparam int DVC_W = $clog2(DVD_W);

  localparam logic [COUNT_BITS-1:0] CNT_MAX    = '1;
  localparam logic [PCT_W-1:0]      PCT_SCALE  = PCT_W'(10000);
  localparam logic [6:0]            DOSE_SCALE = 7'd100;
  localparam logic [TD_W-1:0]       TD_RESET   = TD_W'(10000);

  localparam logic [CFG_IDX_W-1:0] CFG_TREATMENT_DOSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AIR_ZONE       = 2'd1;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [ZONE_W-1:0]  zone_id;
    logic [DOSE_W-1:0]  dose;
    logic [LEVEL_W-1:0] level;
  } in_item_t;

  typedef struct packed {
    logic [PCT_W-1:0] percent;
    logic             zone_present;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [ZONE_W-1:0] zone;
    logic [ARG_W-1:0]  arg;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SEARCH,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_ACC,
    B_SUM,
    B_DRAIN,
    B_MUL,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

// File: hdl/cdvh_ram.sv
`timescale 1ns / 1ps
module cdvh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/cdvh_queue.sv
`timescale 1ns / 1ps
module cdvh_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  cdvh_pkg::cmd_t wr_data,
  input  logic          rd_en,
  output cdvh_pkg::cmd_t rd_data,
  output logic          full,
  output logic          empty
);

  cdvh_pkg::cmd_t slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full    = (count == 3'd4);
  assign empty   = (count == 3'd0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (rd_en && !empty) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'((wr_en && !full) ? 1 : 0) - 3'((rd_en && !empty) ? 1 : 0);
    end
  end

endmodule

// File: hdl/cdvh_front.sv
`timescale 1ns / 1ps
module cdvh_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  cdvh_pkg::in_item_t            in_item,
  output logic                          full,
  input  logic [cdvh_pkg::TD_W-1:0]     treatment_dose,
  input  logic [cdvh_pkg::ZONE_W-1:0]   air_zone,
  input  logic                          init_busy,
  input  logic                          q_full,
  output cdvh_pkg::cmd_t                cmd,
  output logic                          cmd_push
);

  cdvh_pkg::front_state_t state, state_next;
  logic [cdvh_pkg::SCALE_W-1:0] scaled;
  logic [cdvh_pkg::PROD_W-1:0]  prod;
  logic [cdvh_pkg::SRCH_W-1:0]  q;
  logic [cdvh_pkg::SB_W-1:0]    bitpos;

  logic                         accept;
  logic                         zone_ok;
  logic [cdvh_pkg::PROD_W-1:0]  cand;
  logic                         take;
  logic [cdvh_pkg::SRCH_W-1:0]  q_new;
  logic [cdvh_pkg::SRCH_W:0]    q_inc;
  logic [cdvh_pkg::ARG_W-1:0]   passed;

  assign full     = (state != cdvh_pkg::F_IDLE) || init_busy;
  assign accept   = push && !full;
  assign cmd_push = (state == cdvh_pkg::F_PUSH) && !q_full;
  assign zone_ok  = ({1'b0, in_item.zone_id} < (cdvh_pkg::ZONE_W + 1)'(cdvh_pkg::ZONE_COUNT))
                    && (in_item.zone_id != air_zone);

  // one quotient bit per cycle: largest q with treatment_dose*q below the scaled dose
  assign cand  = prod + (cdvh_pkg::PROD_W'(treatment_dose) << bitpos);
  assign take  = cand < cdvh_pkg::PROD_W'(scaled);
  assign q_new = take ? (q | (cdvh_pkg::SRCH_W'(1) << bitpos)) : q;
  assign q_inc = {1'b0, q_new} + (cdvh_pkg::SRCH_W + 1)'(1);
  always_comb begin
    if (scaled == '0) begin
      passed = '0;
    end else if (cdvh_pkg::ARG_W'(q_inc) >= cdvh_pkg::ARG_W'(cdvh_pkg::LEVEL_COUNT)
                 || q_inc[cdvh_pkg::SRCH_W]) begin
      passed = cdvh_pkg::ARG_W'(cdvh_pkg::LEVEL_COUNT);
    end else begin
      passed = cdvh_pkg::ARG_W'(q_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdvh_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cdvh_pkg::F_IDLE: begin
        if (accept) begin
          case (in_item.opcode)
            cdvh_pkg::OP_ACC:   state_next = zone_ok ? cdvh_pkg::F_SEARCH : cdvh_pkg::F_IDLE;
            cdvh_pkg::OP_READ:  state_next = cdvh_pkg::F_PUSH;
            cdvh_pkg::OP_CLEAR: state_next = cdvh_pkg::F_PUSH;
            default:            state_next = cdvh_pkg::F_IDLE;
          endcase
        end
      end
      cdvh_pkg::F_SEARCH: begin
        if (bitpos == '0) begin
          state_next = cdvh_pkg::F_PUSH;
        end
      end
      cdvh_pkg::F_PUSH: begin
        if (!q_full) begin
          state_next = cdvh_pkg::F_IDLE;
        end
      end
      default: state_next = cdvh_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == cdvh_pkg::F_IDLE && accept) begin
      cmd.op   <= cdvh_pkg::op_t'(in_item.opcode);
      cmd.zone <= in_item.zone_id;
      cmd.arg  <= cdvh_pkg::ARG_W'(in_item.level);
      scaled   <= cdvh_pkg::SCALE_W'(in_item.dose) * cdvh_pkg::SCALE_W'(cdvh_pkg::DOSE_SCALE);
      prod     <= '0;
      q        <= '0;
      bitpos   <= cdvh_pkg::SB_W'(cdvh_pkg::SRCH_W - 1);
    end else if (state == cdvh_pkg::F_SEARCH) begin
      q <= q_new;
      if (take) begin
        prod <= cand;
      end
      bitpos <= bitpos - cdvh_pkg::SB_W'(1);
      if (bitpos == '0) begin
        cmd.arg <= passed;
      end
    end
  end

endmodule

// File: hdl/cdvh_back.sv
`timescale 1ns / 1ps
module cdvh_back (
  input  logic                clk,
  input  logic                rst,
  input  cdvh_pkg::cmd_t      cmd,
  input  logic                q_empty,
  output logic                q_pop,
  output cdvh_pkg::out_item_t out_item,
  output logic                empty,
  input  logic                pop,
  output logic                init_busy
);

  localparam int CB = cdvh_pkg::COUNT_BITS;

  cdvh_pkg::back_state_t state, state_next;

  logic [cdvh_pkg::BIN_AW-1:0] row;
  logic [cdvh_pkg::BIN_AW-1:0] wr_addr;
  logic [cdvh_pkg::BIN_AW-1:0] clr_addr;
  logic [cdvh_pkg::ARG_W-1:0]  j;
  logic                        rd_pend;
  logic [cdvh_pkg::SUM_W-1:0]  sum;
  logic [CB-1:0]               tot;
  logic [cdvh_pkg::DVD_W-1:0]  dvd;
  logic [CB-1:0]               rem;
  logic [cdvh_pkg::PCT_W-1:0]  qv;
  logic [cdvh_pkg::DVC_W-1:0]  dcnt;
  logic                        present;
  logic                        out_valid;
  logic [CB-1:0]               totals [cdvh_pkg::ZONE_COUNT];

  logic                        ram_we;
  logic [cdvh_pkg::BIN_AW-1:0] ram_waddr;
  logic [CB-1:0]               ram_wdata;
  logic [cdvh_pkg::BIN_AW-1:0] ram_raddr;
  logic [CB-1:0]               ram_rdata;

  logic                        zone_ok;
  logic [CB-1:0]               head_tot;
  logic [cdvh_pkg::BIN_AW-1:0] head_row;
  logic                        short_read;
  logic                        out_free;
  logic [CB:0]                 rem_sh;
  logic                        ge;
  logic [CB-1:0]               clamped;

  assign init_busy = (state == cdvh_pkg::B_INIT);
  assign empty     = !out_valid;
  assign out_free  = !out_valid || pop;
  assign zone_ok   = {1'b0, cmd.zone} < (cdvh_pkg::ZONE_W + 1)'(cdvh_pkg::ZONE_COUNT);
  assign head_tot  = zone_ok ? totals[cmd.zone] : '0;
  assign head_row  = cdvh_pkg::BIN_AW'(cmd.zone) * cdvh_pkg::BIN_AW'(cdvh_pkg::ROW_STRIDE);
  assign short_read = (head_tot == '0)
                      || (cmd.arg >= cdvh_pkg::ARG_W'(cdvh_pkg::LEVEL_COUNT));
  assign rem_sh    = {rem, dvd[cdvh_pkg::DVD_W-1]};
  assign ge        = rem_sh >= {1'b0, tot};
  assign clamped   = (sum > cdvh_pkg::SUM_W'(cdvh_pkg::CNT_MAX)) ? cdvh_pkg::CNT_MAX : CB'(sum);

  cdvh_ram #(
    .WIDTH (CB),
    .DEPTH (cdvh_pkg::BIN_DEPTH)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdvh_pkg::B_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = wr_addr;
    ram_wdata  = '0;
    ram_raddr  = row + cdvh_pkg::BIN_AW'(j);
    case (state)
      cdvh_pkg::B_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        if (clr_addr == cdvh_pkg::BIN_AW'(cdvh_pkg::BIN_DEPTH - 1)) begin
          state_next = cdvh_pkg::B_IDLE;
        end
      end
      cdvh_pkg::B_IDLE: begin
        ram_raddr = head_row + cdvh_pkg::BIN_AW'(cmd.arg);
        if (!q_empty) begin
          q_pop = 1'b1;
          case (cmd.op)
            cdvh_pkg::OP_ACC:   state_next = cdvh_pkg::B_ACC;
            cdvh_pkg::OP_READ:  state_next = short_read ? cdvh_pkg::B_OUT : cdvh_pkg::B_SUM;
            cdvh_pkg::OP_CLEAR: state_next = cdvh_pkg::B_INIT;
            default:            state_next = cdvh_pkg::B_IDLE;
          endcase
        end
      end
      cdvh_pkg::B_ACC: begin
        ram_we     = 1'b1;
        ram_wdata  = (ram_rdata == cdvh_pkg::CNT_MAX) ? cdvh_pkg::CNT_MAX : ram_rdata + CB'(1);
        state_next = cdvh_pkg::B_IDLE;
      end
      cdvh_pkg::B_SUM: begin
        if (j == cdvh_pkg::ARG_W'(cdvh_pkg::LEVEL_COUNT)) begin
          state_next = cdvh_pkg::B_DRAIN;
        end
      end
      cdvh_pkg::B_DRAIN: state_next = cdvh_pkg::B_MUL;
      cdvh_pkg::B_MUL:   state_next = cdvh_pkg::B_DIV;
      cdvh_pkg::B_DIV: begin
        if (dcnt == '0) begin
          state_next = cdvh_pkg::B_OUT;
        end
      end
      cdvh_pkg::B_OUT: begin
        if (out_free) begin
          state_next = cdvh_pkg::B_IDLE;
        end
      end
      default: state_next = cdvh_pkg::B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      out_valid <= 1'b0;
      for (int z = 0; z < cdvh_pkg::ZONE_COUNT; z++) begin
        totals[z] <= '0;
      end
    end else begin
      if (state == cdvh_pkg::B_INIT) begin
        clr_addr <= (state_next == cdvh_pkg::B_INIT) ? clr_addr + cdvh_pkg::BIN_AW'(1) : '0;
      end
      if (state == cdvh_pkg::B_IDLE && !q_empty) begin
        if (cmd.op == cdvh_pkg::OP_ACC && zone_ok) begin
          totals[cmd.zone] <= (head_tot == cdvh_pkg::CNT_MAX) ?
                              cdvh_pkg::CNT_MAX : head_tot + CB'(1);
        end else if (cmd.op == cdvh_pkg::OP_CLEAR) begin
          for (int z = 0; z < cdvh_pkg::ZONE_COUNT; z++) begin
            totals[z] <= '0;
          end
        end
      end
      if (state == cdvh_pkg::B_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      cdvh_pkg::B_IDLE: begin
        row     <= head_row;
        wr_addr <= head_row + cdvh_pkg::BIN_AW'(cmd.arg);
        j       <= cmd.arg + cdvh_pkg::ARG_W'(1);
        tot     <= head_tot;
        present <= (head_tot != '0);
        rd_pend <= 1'b0;
        sum     <= '0;
        qv      <= '0;
      end
      cdvh_pkg::B_SUM: begin
        rd_pend <= 1'b1;
        if (rd_pend) begin
          sum <= sum + cdvh_pkg::SUM_W'(ram_rdata);
        end
        j <= j + cdvh_pkg::ARG_W'(1);
      end
      cdvh_pkg::B_DRAIN: begin
        sum <= sum + cdvh_pkg::SUM_W'(ram_rdata);
      end
      cdvh_pkg::B_MUL: begin
        dvd  <= cdvh_pkg::DVD_W'(clamped) * cdvh_pkg::DVD_W'(cdvh_pkg::PCT_SCALE);
        rem  <= '0;
        dcnt <= cdvh_pkg::DVC_W'(cdvh_pkg::DVD_W - 1);
      end
      cdvh_pkg::B_DIV: begin
        rem  <= ge ? CB'(rem_sh - {1'b0, tot}) : CB'(rem_sh);
        dvd  <= dvd << 1;
        qv   <= {qv[cdvh_pkg::PCT_W-2:0], ge};
        dcnt <= dcnt - cdvh_pkg::DVC_W'(1);
      end
      cdvh_pkg::B_OUT: begin
        if (out_free) begin
          out_item.percent      <= qv;
          out_item.zone_present <= present;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/cumulative_dose_volume_histogram_top.sv
`timescale 1ns / 1ps
// accumulate: the front runs a 7-step level search, then the back updates one bin
// read: an empty zone or a level out of range goes straight to the result; else the bin
// sum (one ram read per level) and the 34-step divider run first
// the front takes a new accumulate only once its level search and queue push are done
// rst is synchronous, active high; after rst and after a clear transaction the bin ram
// is swept to zero, with full held high during each sweep
module cumulative_dose_volume_histogram_top (
  input  logic                                clk,
  input  logic                                rst,
  // input queue side
  input  logic                                push,
  output logic                                full,
  input  cdvh_pkg::in_item_t                  in_item,
  // result queue side
  output logic                                empty,
  input  logic                                pop,
  output cdvh_pkg::out_item_t                 out_item,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cdvh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cdvh_pkg::CFG_DAT_W-1:0]      cfg_data
);

  logic [cdvh_pkg::TD_W-1:0]   treatment_dose;
  logic [cdvh_pkg::ZONE_W-1:0] air_zone;

  cdvh_pkg::cmd_t front_cmd;
  cdvh_pkg::cmd_t head_cmd;
  logic           cmd_push;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic           init_busy;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      treatment_dose <= cdvh_pkg::TD_RESET;
      air_zone       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cdvh_pkg::CFG_TREATMENT_DOSE: treatment_dose <= cfg_data;
        cdvh_pkg::CFG_AIR_ZONE:       air_zone       <= cfg_data[cdvh_pkg::ZONE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: takes transactions, drops air samples, finds number of levels passed
  cdvh_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .in_item        (in_item),
    .full           (full),
    .treatment_dose (treatment_dose),
    .air_zone       (air_zone),
    .init_busy      (init_busy),
    .q_full         (q_full),
    .cmd            (front_cmd),
    .cmd_push       (cmd_push)
  );

  // short command queue between the two halves
  cdvh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (front_cmd),
    .rd_en   (q_pop),
    .rd_data (head_cmd),
    .full    (q_full),
    .empty   (q_empty)
  );

  // back: bin ram sweep, bin updates, cumulative sums, percentage divide, result register
  cdvh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_item  (out_item),
    .empty     (empty),
    .pop       (pop),
    .init_busy (init_busy)
  );

  // a result never exceeds full scale
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_item.percent <= cdvh_pkg::PCT_SCALE))
    else $error("percent above full scale");

  // an empty zone reports zero share
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_item.zone_present) |-> (out_item.percent == '0))
    else $error("nonzero percent for empty zone");

  // no transaction taken while the bin ram sweep runs
  assert property (@(posedge clk) disable iff (rst)
    init_busy |-> full)
    else $error("input open during clearing sweep");

  // a waiting result holds until popped
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed");

endmodule

// File: dv/tb_cumulative_dose_volume_histogram_top.sv
`timescale 1ns / 1ps
module tb_cumulative_dose_volume_histogram_top;
  import cdvh_pkg::*;

  // opcode with no function: accepted, no effect, no result
  localparam logic [1:0] OP_NOP = 2'd3;
  // idle time before a register write: clear sweep plus pipeline drain
  localparam int SETTLE_CYCLES = 2000;
  localparam int HOLD_CYCLES   = 800;

  // histogram predictor and store of expected read results
  class dvh_scoreboard;
    logic [COUNT_BITS-1:0] bin_count[ZONE_COUNT][LEVEL_COUNT];
    logic [COUNT_BITS-1:0] zone_cells[ZONE_COUNT];
    logic [TD_W-1:0]       rx_dose;
    logic [ZONE_W-1:0]     air;
    out_item_t             read_q[$];
    int                    fail_count;

    function new();
      wipe();
      rx_dose    = TD_RESET;
      air        = '0;
      fail_count = 0;
    endfunction

    function void wipe();
      foreach (zone_cells[z]) zone_cells[z] = '0;
      foreach (bin_count[z, i]) bin_count[z][i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      if (idx == CFG_TREATMENT_DOSE) rx_dose = val[TD_W-1:0];
      else if (idx == CFG_AIR_ZONE) air = val[ZONE_W-1:0];
    endfunction

    function void note_item(in_item_t it);
      longint unsigned scaled;
      longint unsigned cnt;
      longint unsigned tot;
      longint unsigned pct;
      out_item_t       exp_res;
      scaled = longint'(it.dose) * 100;
      case (it.opcode)
        OP_ACC: begin
          if (it.zone_id != air) begin
            if (zone_cells[it.zone_id] != CNT_MAX) zone_cells[it.zone_id]++;
            for (int i = 0; i < LEVEL_COUNT; i++) begin
              if (scaled > longint'(rx_dose) * i &&
                  bin_count[it.zone_id][i] != CNT_MAX)
                bin_count[it.zone_id][i]++;
            end
          end
        end
        OP_READ: begin
          tot = zone_cells[it.zone_id];
          pct = 0;
          if (tot != 0 && it.level < LEVEL_COUNT) begin
            cnt = bin_count[it.zone_id][it.level];
            pct = (cnt * 10000) / tot;
            if (pct > 10000) pct = 10000;
          end
          exp_res.percent      = pct[PCT_W-1:0];
          exp_res.zone_present = (tot != 0);
          read_q.push_back(exp_res);
        end
        OP_CLEAR: wipe();
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      fail_count++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (read_q.size() == 0) begin
        report($sformatf("unexpected result pct=%0d present=%0d",
                         got.percent, got.zone_present));
        return;
      end
      want = read_q.pop_front();
      if (got.percent !== want.percent)
        report($sformatf("percent got %0d want %0d", got.percent, want.percent));
      if (got.zone_present !== want.zone_present)
        report($sformatf("zone_present got %0d want %0d",
                         got.zone_present, want.zone_present));
    endtask

    function int outstanding();
      return read_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  in_item_t             in_item;
  logic                 empty;
  logic                 pop;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  dvh_scoreboard sb = new();
  bit            quiet;      // no random gaps on either side while set
  logic          hold_off;   // long receiver stall for back-pressure
  logic          burst_go;

  cumulative_dose_volume_histogram_top u_top (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones, none while quiet
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: check every popped result, then pick the next pop
  int rx_hold;
  always @(posedge clk) begin
    if (rst) begin
      pop     <= 1'b0;
      rx_hold <= 0;
    end else begin
      if (pop && !empty) sb.check_result(out_item);
      if (hold_off) begin
        pop <= 1'b0;
      end else if (rx_hold > 0) begin
        pop     <= 1'b0;
        rx_hold <= rx_hold - 1;
      end else begin
        pop     <= 1'b1;
        rx_hold <= pick_gap();
      end
    end
  end

  // long receiver stall so the result side backs up into the input
  initial begin
    hold_off = 1'b0;
    @(posedge burst_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // one input transaction: optional gap, then hold push until accepted
  task automatic send(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    sb.note_item(it);
  endtask

  task automatic send_fields(logic [1:0] op, logic [ZONE_W-1:0] zone,
                             logic [DOSE_W-1:0] dose, logic [LEVEL_W-1:0] lvl);
    in_item_t it;
    it.opcode  = op;
    it.zone_id = zone;
    it.dose    = dose;
    it.level   = lvl;
    send(it);
  endtask

  // register write, only once every read has returned and the block has settled
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // random dose: extremes, values around a level threshold, or anything
  function automatic logic [DOSE_W-1:0] pick_dose();
    int unsigned r;
    longint unsigned edge_val;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 6) begin
      edge_val = (longint'(sb.rx_dose) * $urandom_range(0, LEVEL_COUNT)) / 100;
      edge_val = edge_val + $urandom_range(0, 2);
      if (edge_val > 65535) edge_val = 65535;
      return edge_val[DOSE_W-1:0];
    end
    return DOSE_W'($urandom());
  endfunction

  task automatic random_items(int n, int read_pct);
    int unsigned r;
    logic [1:0]  op;
    logic [LEVEL_W-1:0] lvl;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 999);
      if (r < 8) op = OP_CLEAR;
      else if (r < 30) op = OP_NOP;
      else if (r < 30 + read_pct * 10) op = OP_READ;
      else op = OP_ACC;
      lvl = ($urandom_range(0, 9) == 0) ? LEVEL_W'($urandom_range(LEVEL_COUNT, 127))
                                         : LEVEL_W'($urandom_range(0, LEVEL_COUNT - 1));
      // a few zones take most samples so reads see real histograms
      send_fields(op, ($urandom_range(0, 3) == 0) ? ZONE_W'($urandom())
                                                  : ZONE_W'($urandom_range(1, 4)),
                  pick_dose(), lvl);
      if ($urandom_range(0, 49) == 0) quiet = !quiet;
    end
  endtask

  initial begin
    rst       = 1'b1;
    push      = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    burst_go  = 1'b0;
    quiet     = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty zone, air zone, dose extremes and threshold edges
    send_fields(OP_READ, 4'd5, '0, 7'd0);
    send_fields(OP_ACC, 4'd5, 16'd0, '0);
    send_fields(OP_ACC, 4'd5, 16'hFFFF, '0);
    send_fields(OP_ACC, 4'd5, 16'd10000, '0);
    send_fields(OP_ACC, 4'd5, 16'd10001, '0);
    send_fields(OP_ACC, 4'd0, 16'd5000, '0);
    send_fields(OP_READ, 4'd0, '0, 7'd0);
    send_fields(OP_ACC, 4'd15, 16'd5000, '0);
    send_fields(OP_READ, 4'd5, '0, 7'd0);
    send_fields(OP_READ, 4'd5, '0, 7'd1);
    send_fields(OP_READ, 4'd5, '0, 7'd99);
    send_fields(OP_READ, 4'd5, '0, 7'd100);
    send_fields(OP_READ, 4'd5, '0, 7'd109);
    send_fields(OP_READ, 4'd5, '0, 7'd110);
    send_fields(OP_READ, 4'd5, '1, 7'd127);
    send_fields(OP_READ, 4'd15, '0, 7'd49);
    send_fields(OP_READ, 4'd15, '0, 7'd50);
    send_fields(OP_NOP, 4'd5, 16'hFFFF, 7'd5);
    send_fields(OP_READ, 4'd5, '0, 7'd2);
    send_fields(OP_CLEAR, '0, '0, '0);
    send_fields(OP_READ, 4'd5, '0, 7'd0);
    send_fields(OP_READ, 4'd15, '0, 7'd0);

    // fill the histograms, then a read burst against a stalled receiver
    random_items(80, 10);
    quiet = 1'b1;
    burst_go <= 1'b1;
    for (int k = 0; k < 60; k++)
      send_fields(OP_READ, ZONE_W'($urandom_range(1, 4)), '0,
                  LEVEL_W'($urandom_range(0, LEVEL_COUNT - 1)));
    quiet = 1'b0;
    random_items(100, 30);

    // registers keep the counters; a former air zone can still be read
    write_reg(CFG_AIR_ZONE, 16'd3);
    write_reg(CFG_TREATMENT_DOSE, 16'd1);
    send_fields(OP_READ, 4'd3, '0, 7'd10);
    send_fields(OP_READ, 4'd0, '0, 7'd10);
    random_items(130, 25);

    write_reg(CFG_TREATMENT_DOSE, 16'hFFFF);
    write_reg(CFG_AIR_ZONE, 16'd15);
    random_items(130, 25);

    // zero treatment dose: any nonzero dose passes every level
    write_reg(CFG_TREATMENT_DOSE, 16'd0);
    write_reg(CFG_AIR_ZONE, 16'd0);
    send_fields(OP_ACC, 4'd2, 16'd0, '0);
    send_fields(OP_ACC, 4'd2, 16'd1, '0);
    send_fields(OP_READ, 4'd2, '0, 7'd109);
    random_items(100, 25);

    write_reg(CFG_TREATMENT_DOSE, 16'($urandom_range(1, 65535)));
    write_reg(CFG_AIR_ZONE, 16'($urandom_range(0, 15)));
    random_items(150, 25);

    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
hdl/cdvh_pkg.sv
hdl/cdvh_ram.sv
hdl/cdvh_queue.sv
hdl/cdvh_front.sv
hdl/cdvh_back.sv
hdl/cumulative_dose_volume_histogram_top.sv
dv/tb_cumulative_dose_volume_histogram_top.sv
